FILE: src/fle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_pkg: shared types and constants of the free-list entry table
// Field widths, operation and status codes, controller states and the
// structs that pass between the controller, the slot store and the top level.
// ----------------------------------------------------------------------------
package fle_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 6;
  localparam int FREE_W   = 7;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_W  = 104;
  localparam int OUT_W = 16;

  // Link value that marks the sentinel slot at the end of the table.
  localparam logic [VALUE_W-1:0] LINK_END = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_ADD_TAIL,
    S_MOD,
    S_DEL,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

  typedef struct packed {
    status_t             status;
    logic [FOUND_W-1:0]  found;
    logic [FREE_W-1:0]   free_cnt;
  } res_t;

endpackage
`default_nettype wire

FILE: src/fle_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_store: slot name and link memories
// One write port and one read port, read data registered. Slot 0 reads as
// the empty sentinel until it is first written.
// ----------------------------------------------------------------------------
module fle_store #(
  parameter int DEPTH  = 64,
  parameter int NAME_W = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fle_pkg::mem_cmd_t             cmd,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [NAME_W-1:0]             wr_name,
  input  wire logic [fle_pkg::VALUE_W-1:0]   wr_link,
  output logic      [NAME_W-1:0]             rd_name,
  output logic      [fle_pkg::VALUE_W-1:0]   rd_link
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [NAME_W-1:0]           name_mem [DEPTH];
  logic [fle_pkg::VALUE_W-1:0] link_mem [DEPTH];

  logic [NAME_W-1:0]           rd_name_r;
  logic [fle_pkg::VALUE_W-1:0] rd_link_r;
  logic                        zero_pend_r;
  logic                        rd_zero_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      name_mem[wr_addr] <= wr_name;
      link_mem[wr_addr] <= wr_link;
    end
    if (cmd.rd_en) begin
      rd_name_r <= name_mem[rd_addr];
      rd_link_r <= link_mem[rd_addr];
    end
  end

  // Slot 0 keeps its reset contents until the first write to it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_pend_r <= 1'b1;
      rd_zero_r   <= 1'b0;
    end else begin
      if (cmd.wr_en && (wr_addr == IDX_W'(0))) begin
        zero_pend_r <= 1'b0;
      end
      if (cmd.rd_en) begin
        rd_zero_r <= zero_pend_r && (rd_addr == IDX_W'(0));
      end
    end
  end

  assign rd_name = rd_zero_r ? '0 : rd_name_r;
  assign rd_link = rd_zero_r ? fle_pkg::LINK_END : rd_link_r;

endmodule
`default_nettype wire

FILE: src/fle_lmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_lmod: reduction of a link value modulo the table depth
// Reciprocal multiplication in two register stages, then one conditional
// subtract of the divisor to correct the quotient estimate.
// ----------------------------------------------------------------------------
module fle_lmod #(
  parameter int DIVISOR = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [fle_pkg::VALUE_W-1:0]   dividend,
  output logic                               done,
  output logic      [$clog2(DIVISOR)-1:0]    rem
);

  localparam int IDX_W = $clog2(DIVISOR);
  localparam int REM_W = IDX_W + 1;
  localparam int DVD_W = fle_pkg::VALUE_W;
  localparam int PRD_W = 2 * DVD_W;
  // Reciprocal scaled by 2^32 and rounded down. The quotient taken from the
  // upper product half is then exact or one too small, so the first
  // remainder lies below twice the divisor.
  localparam logic [DVD_W-1:0] RECIP   = DVD_W'((64'd1 << DVD_W) / 64'(DIVISOR));
  localparam logic [DVD_W-1:0] DIV_DVD = DVD_W'(DIVISOR);
  localparam logic [REM_W-1:0] DIV_V   = REM_W'(DIVISOR);

  logic             st1_r;
  logic             st2_r;
  logic [DVD_W-1:0] dvd_r;
  logic [PRD_W-1:0] prod_r;
  logic [REM_W-1:0] diff_r;
  logic [DVD_W-1:0] quot;
  logic [DVD_W-1:0] diff;
  logic [REM_W-1:0] rem_fix;

  always_comb begin
    quot    = prod_r[PRD_W-1:DVD_W];
    diff    = dvd_r - DVD_W'(quot * DIV_DVD);
    rem_fix = (diff_r >= DIV_V) ? (diff_r - DIV_V) : diff_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r <= 1'b0;
      st2_r <= 1'b0;
    end else begin
      st1_r <= start;
      st2_r <= st1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      prod_r <= PRD_W'(dividend) * PRD_W'(RECIP);
    end
    if (st1_r) begin
      diff_r <= diff[REM_W-1:0];
    end
  end

  assign done = st2_r;
  assign rem  = rem_fix[IDX_W-1:0];

endmodule
`default_nettype wire

FILE: src/fle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_ctrl: request sequencer of the free-list entry table
// Holds the free-list head, table length and free counter, and drives the
// read-modify-write accesses to the slot store for add and delete and the reads for search.
// ----------------------------------------------------------------------------
module fle_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int NAME_BYTES  = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [fle_pkg::OP_W-1:0]            in_op,
  input  wire logic [fle_pkg::KEY_W-1:0]           in_key,
  input  wire logic [fle_pkg::VALUE_W-1:0]         in_value,
  input  wire logic [fle_pkg::SLOT_W-1:0]          in_slot,
  output fle_pkg::mem_cmd_t                        mem_cmd,
  output logic      [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
  output logic      [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
  output logic      [8*NAME_BYTES-1:0]             wr_name,
  output logic      [fle_pkg::VALUE_W-1:0]         wr_link,
  input  wire logic [8*NAME_BYTES-1:0]             rd_name,
  input  wire logic [fle_pkg::VALUE_W-1:0]         rd_link,
  output logic                                     mod_start,
  input  wire logic                                mod_done,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]      mod_rem,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output fle_pkg::res_t                            res
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int TL_W   = $clog2(TABLE_DEPTH + 1);
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int FW     = fle_pkg::FOUND_W;
  localparam int CW     = fle_pkg::FREE_W;
  localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(TABLE_DEPTH - 1);

  // Keeps the bytes before the first zero byte, at most NAME_BYTES of them.
  function automatic logic [NAME_W-1:0] norm_name(input logic [fle_pkg::KEY_W-1:0] k);
    logic [NAME_W-1:0] r;
    logic              live;
    r    = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (k[8*b +: 8] == 8'd0) live = 1'b0;
      if (live) r[8*b +: 8] = k[8*b +: 8];
    end
    return r;
  endfunction

  fle_pkg::state_t               state_r, state_nxt;
  logic [fle_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [NAME_W-1:0]             key_r, key_nxt;
  logic [fle_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [fle_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [IDX_W-1:0]              head_r, head_nxt;
  logic [TL_W-1:0]               tl_r, tl_nxt;
  logic [CW-1:0]                 fc_r, fc_nxt;
  logic [TL_W-1:0]               scan_r, scan_nxt;
  logic [TL_W-1:0]               cmp_r, cmp_nxt;
  fle_pkg::status_t              res_status_r, res_status_nxt;
  logic [IDX_W-1:0]              res_found_r, res_found_nxt;

  logic             is_sent;
  logic             is_freed;
  logic             tbl_full;
  logic             del_bad;
  logic             scan_end;
  logic [IDX_W-1:0] slot_idx;

  always_comb begin
    is_sent  = (rd_name[7:0] == 8'd0) && (rd_link == fle_pkg::LINK_END);
    is_freed = (rd_name[7:0] == 8'd0) && (rd_link != fle_pkg::LINK_END);
    tbl_full = 32'(tl_r) >= 32'(TABLE_DEPTH);
    del_bad  = ((32'(slot_r) + 32'd1) >= 32'(tl_r)) || (32'(slot_r) >= 32'(TABLE_DEPTH));
    scan_end = (32'(cmp_r) + 32'd1) >= 32'(tl_r);
    slot_idx = IDX_W'(slot_r);
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    head_nxt       = head_r;
    tl_nxt         = tl_r;
    fc_nxt         = fc_r;
    scan_nxt       = scan_r;
    cmp_nxt        = cmp_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    in_ready       = 1'b0;
    mem_cmd        = '0;
    rd_addr        = head_r;
    wr_addr        = head_r;
    wr_name        = key_r;
    wr_link        = val_r;
    mod_start      = 1'b0;
    res_valid      = 1'b0;

    case (state_r)
      fle_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt         = in_op;
          key_nxt        = norm_name(in_key);
          val_nxt        = in_value;
          slot_nxt       = in_slot;
          res_status_nxt = fle_pkg::ST_OK;
          res_found_nxt  = '0;
          mem_cmd.rd_en  = 1'b1;
          case (in_op)
            fle_pkg::OP_ADD: begin
              rd_addr   = head_r;
              state_nxt = fle_pkg::S_ADD;
            end
            fle_pkg::OP_DEL: begin
              rd_addr   = IDX_W'(in_slot);
              state_nxt = fle_pkg::S_DEL;
            end
            fle_pkg::OP_SEARCH: begin
              rd_addr   = '0;
              cmp_nxt   = '0;
              scan_nxt  = TL_W'(1);
              state_nxt = fle_pkg::S_SEARCH;
            end
            default: begin
              mem_cmd.rd_en = 1'b0;
              state_nxt     = fle_pkg::S_DONE;
            end
          endcase
        end
      end

      fle_pkg::S_ADD: begin
        if (is_sent && tbl_full) begin
          res_status_nxt = fle_pkg::ST_FULL;
          state_nxt      = fle_pkg::S_DONE;
        end else if (is_sent) begin
          mem_cmd.wr_en = 1'b1;
          res_found_nxt = head_r;
          head_nxt      = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;
          tl_nxt        = tl_r + 1'b1;
          fc_nxt        = CW'(1);
          state_nxt     = fle_pkg::S_ADD_TAIL;
        end else begin
          // The old link goes to the reduction unit before the overwrite lands.
          mem_cmd.wr_en = 1'b1;
          res_found_nxt = head_r;
          fc_nxt        = fc_r - 1'b1;
          mod_start     = 1'b1;
          state_nxt     = fle_pkg::S_MOD;
        end
      end

      fle_pkg::S_ADD_TAIL: begin
        mem_cmd.wr_en = 1'b1;
        wr_addr       = IDX_W'(tl_r - 1'b1);
        wr_name       = '0;
        wr_link       = fle_pkg::LINK_END;
        state_nxt     = fle_pkg::S_DONE;
      end

      fle_pkg::S_MOD: begin
        if (mod_done) begin
          head_nxt  = mod_rem;
          state_nxt = fle_pkg::S_DONE;
        end
      end

      fle_pkg::S_DEL: begin
        if (del_bad) begin
          res_status_nxt = fle_pkg::ST_BAD_INDEX;
        end else if (is_freed) begin
          res_status_nxt = fle_pkg::ST_EMPTY;
        end else begin
          mem_cmd.wr_en = 1'b1;
          wr_addr       = slot_idx;
          wr_name       = '0;
          wr_link       = fle_pkg::VALUE_W'(head_r);
          head_nxt      = slot_idx;
          fc_nxt        = fc_r + 1'b1;
        end
        state_nxt = fle_pkg::S_DONE;
      end

      fle_pkg::S_SEARCH: begin
        if (rd_name == key_r) begin
          res_found_nxt = IDX_W'(cmp_r);
          state_nxt     = fle_pkg::S_DONE;
        end else if (scan_end) begin
          res_status_nxt = fle_pkg::ST_NOT_FOUND;
          state_nxt      = fle_pkg::S_DONE;
        end else begin
          mem_cmd.rd_en = 1'b1;
          rd_addr       = IDX_W'(scan_r);
          cmp_nxt       = scan_r;
          scan_nxt      = scan_r + 1'b1;
        end
      end

      fle_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = fle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fle_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fle_pkg::S_IDLE;
      head_r  <= '0;
      tl_r    <= TL_W'(1);
      fc_r    <= CW'(1);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tl_r    <= tl_nxt;
      fc_r    <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    scan_r       <= scan_nxt;
    cmp_r        <= cmp_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
  end

  assign res.status   = res_status_r;
  assign res.found    = FW'(res_found_r);
  assign res.free_cnt = fc_r;

endmodule
`default_nettype wire

FILE: src/free_list_entry_table.sv
`timescale 1ns / 1ps
`default_nettype none
// From accepting a request to loading its result into the output register, the controller
// passes these states before S_DONE: none for an unused op, S_DEL for a delete, S_ADD for an
// add into a full table, S_ADD and S_ADD_TAIL for an add that grows the table, S_ADD and S_MOD
// (two-stage link reduction) for an add into a freed slot, and S_SEARCH for a search.
// One request at a time: in_tready returns the cycle after the result is loaded, and that load
// waits while an earlier result is held in the output register by a stall.
// Reset: synchronous; control registers clear at once, the memories are not swept (no clearing pass).
// ----------------------------------------------------------------------------
// free_list_entry_table: slot allocator table with a threaded free list
// Name/value slots in on-chip memories, free slots chained through their
// link field, with add, delete and name search requests on a stream port.
// ----------------------------------------------------------------------------
//
// Request and result timing in detail:
//   - Plain add into a freed slot costs the read of the head slot, the
//     write-back of the new entry and a two-stage reciprocal reduction of the
//     old link modulo the table depth, which becomes the new free-list head.
//   - Add at the sentinel writes the new entry and then, with a second write,
//     the new sentinel one slot further; the table grows by one.
//   - Delete reads the slot, then checks it and writes it back only if it passes.
//   - Search streams the slots from slot 0 through the single read port,
//     comparing each name in the cycle after its read is issued.
// All state updates are complete before the controller returns to idle, so
// no two memory accesses of different requests ever overlap.
//
// Slot 0 reads as the empty sentinel until it is first written; every other
// slot is written before the table can reach it.
module free_list_entry_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int NAME_BYTES  = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // op [1:0], key_name [65:2], value [97:66], slot [103:98]
  input  wire logic [fle_pkg::IN_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // status [2:0], found_slot [8:3], free_slots [15:9]
  output logic      [fle_pkg::OUT_W-1:0]   out_tdata
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int NAME_W = 8 * NAME_BYTES;

  // Request fields unpacked from the input stream word.
  logic [fle_pkg::OP_W-1:0]    in_op;
  logic [fle_pkg::KEY_W-1:0]   in_key;
  logic [fle_pkg::VALUE_W-1:0] in_value;
  logic [fle_pkg::SLOT_W-1:0]  in_slot;

  assign in_op    = in_tdata[1:0];
  assign in_key   = in_tdata[65:2];
  assign in_value = in_tdata[97:66];
  assign in_slot  = in_tdata[103:98];

  fle_pkg::mem_cmd_t           mem_cmd;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic [NAME_W-1:0]           wr_name;
  logic [fle_pkg::VALUE_W-1:0] wr_link;
  logic [NAME_W-1:0]           rd_name;
  logic [fle_pkg::VALUE_W-1:0] rd_link;
  logic                        mod_start;
  logic                        mod_done;
  logic [IDX_W-1:0]            mod_rem;
  logic                        res_valid;
  logic                        res_ready;
  fle_pkg::res_t               res;

  logic                        out_tvalid_r;
  logic [fle_pkg::OUT_W-1:0]   out_tdata_r;

  fle_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_op),
    .in_key    (in_key),
    .in_value  (in_value),
    .in_slot   (in_slot),
    .mem_cmd   (mem_cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_name   (wr_name),
    .wr_link   (wr_link),
    .rd_name   (rd_name),
    .rd_link   (rd_link),
    .mod_start (mod_start),
    .mod_done  (mod_done),
    .mod_rem   (mod_rem),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  fle_store #(
    .DEPTH  (TABLE_DEPTH),
    .NAME_W (NAME_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_name (wr_name),
    .wr_link (wr_link),
    .rd_name (rd_name),
    .rd_link (rd_link)
  );

  // The link read from the head slot feeds the reduction unit directly.
  fle_lmod #(
    .DIVISOR (TABLE_DEPTH)
  ) u_lmod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (rd_link),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Output register: a finished result waits here while the controller is
  // already free to take the next request.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {res.free_cnt, res.found, res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

FILE: src/fle_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_chk: port-level checks of the free-list entry table
// Watches the request and result streams of the top level.
// ----------------------------------------------------------------------------
module fle_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [fle_pkg::IN_W-1:0]    in_tdata,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [fle_pkg::OUT_W-1:0]   out_tdata
);

  logic fail_status;

  assign fail_status = (out_tdata[2:0] == fle_pkg::ST_FULL)
                    || (out_tdata[2:0] == fle_pkg::ST_BAD_INDEX)
                    || (out_tdata[2:0] == fle_pkg::ST_EMPTY)
                    || (out_tdata[2:0] == fle_pkg::ST_NOT_FOUND);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request at a time: the port closes right after an accept.
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  // A new result only appears at the end of a request's work.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a request in progress");

  // Failed requests report slot zero.
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fail_status |-> out_tdata[8:3] == '0)
    else $error("failed request reports a slot");

endmodule

bind free_list_entry_table fle_chk u_fle_chk (.*);
`default_nettype wire
